>>> hw/rtl/efapi_pkg.sv
`timescale 1ns / 1ps

package efapi_pkg;

	localparam int ANGLE_W   = 8;
	localparam int TIME_W    = 16;
	localparam int JOINTS    = 4;
	localparam int REG_IDX_W = 3;

	typedef logic [ANGLE_W-1:0]             angle_t;
	typedef logic [JOINTS-1:0][ANGLE_W-1:0] pose_t;
	typedef logic [TIME_W-1:0]              ms_t;
	typedef logic [REG_IDX_W-1:0]           reg_idx_t;

	// item kind carried on tuser
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef enum logic [1:0] {
		CURVE_LINEAR   = 2'd0,
		CURVE_EASE_IN  = 2'd1,
		CURVE_EASE_OUT = 2'd2,
		CURVE_IN_OUT   = 2'd3
	} curve_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_MUL1,
		ST_MUL2,
		ST_BLEND,
		ST_OUT
	} state_t;

	localparam reg_idx_t REG_BASE_MIN   = 3'd0;
	localparam reg_idx_t REG_BASE_MAX   = 3'd1;
	localparam reg_idx_t REG_LOWER_MIN  = 3'd2;
	localparam reg_idx_t REG_LOWER_MAX  = 3'd3;
	localparam reg_idx_t REG_MIDDLE_MIN = 3'd4;
	localparam reg_idx_t REG_MIDDLE_MAX = 3'd5;
	localparam reg_idx_t REG_HEAD_MIN   = 3'd6;
	localparam reg_idx_t REG_HEAD_MAX   = 3'd7;

	localparam angle_t NEUTRAL_ANGLE   = 8'd90;
	localparam angle_t NEUTRAL_TOL     = 8'd10;
	localparam angle_t LIMIT_MIN_RESET = 8'd0;
	localparam angle_t LIMIT_MAX_RESET = 8'd180;

endpackage

>>> hw/rtl/efapi_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle: quo = (num << FRAC_BITS) / den.
// Expects num < den, so the quotient fits in FRAC_BITS bits.
module efapi_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  efapi_pkg::ms_t           num,
	input  efapi_pkg::ms_t           den,
	output logic                     done,
	output logic [FRAC_BITS-1:0]     quo
);

	localparam int CNT_W = $clog2(FRAC_BITS);

	logic [CNT_W-1:0]           cnt_q;
	logic                       run_q;
	logic                       done_q;
	efapi_pkg::ms_t             rem_q;
	efapi_pkg::ms_t             den_q;
	logic [FRAC_BITS-1:0]       quo_q;
	logic [efapi_pkg::TIME_W:0] rem_dbl;
	logic [efapi_pkg::TIME_W:0] rem_sub;
	logic                       ge;

	assign rem_dbl = {rem_q, 1'b0};
	assign ge      = rem_dbl >= {1'b0, den_q};
	assign rem_sub = rem_dbl - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? rem_sub[efapi_pkg::TIME_W-1:0] : rem_dbl[efapi_pkg::TIME_W-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

>>> hw/rtl/efapi_mul.sv
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// Only the upper part is kept: hi = (a * b) >> FRAC_BITS.
module efapi_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [FRAC_BITS+1:0]   a,
	input  logic [FRAC_BITS-1:0]   b,
	output logic                   done,
	output logic [FRAC_BITS+1:0]   hi
);

	localparam int CNT_W = $clog2(FRAC_BITS);

	logic [CNT_W-1:0]       cnt_q;
	logic                   run_q;
	logic                   done_q;
	logic [FRAC_BITS+1:0]   a_q;
	logic [FRAC_BITS-1:0]   b_q;
	logic [FRAC_BITS+1:0]   hi_q;
	logic [FRAC_BITS+2:0]   sum;

	// hi stays below a, so the partial sum never overflows one extra bit
	assign sum = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
		end else if (run_q) begin
			hi_q <= sum[FRAC_BITS+2:1];
			b_q  <= {1'b0, b_q[FRAC_BITS-1:1]};
		end
	end

	assign done = done_q;
	assign hi   = hi_q;

endmodule

>>> hw/rtl/efapi_blend.sv
`timescale 1ns / 1ps

// Four joint lanes that walk the eased fraction one bit per cycle:
// v = (start * (ONE - e) + goal * e) >> FRAC_BITS, then clamp to limits.
module efapi_blend #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [FRAC_BITS:0]   e,
	input  efapi_pkg::pose_t     start_pose,
	input  efapi_pkg::pose_t     goal_pose,
	input  efapi_pkg::pose_t     lim_min,
	input  efapi_pkg::pose_t     lim_max,
	output logic                 done,
	output efapi_pkg::pose_t     pose
);

	localparam int CNT_W  = $clog2(FRAC_BITS + 1);
	localparam int ACC_W  = efapi_pkg::ANGLE_W + 1;
	localparam int SUM_W  = efapi_pkg::ANGLE_W + 2;

	logic [CNT_W-1:0]                       cnt_q;
	logic                                   run_q;
	logic                                   done_q;
	logic [FRAC_BITS:0]                     e_q;
	logic [FRAC_BITS:0]                     w_q;
	logic [efapi_pkg::JOINTS-1:0][ACC_W-1:0] acc_q;
	logic [efapi_pkg::JOINTS-1:0][SUM_W-1:0] sum;
	efapi_pkg::pose_t                       clamped;
	efapi_pkg::pose_t                       pose_q;
	logic                                   last;

	assign last = cnt_q == CNT_W'(FRAC_BITS);

	always_comb begin
		for (int k = 0; k < efapi_pkg::JOINTS; k++) begin
			sum[k] = {1'b0, acc_q[k]}
			       + (e_q[0] ? {2'b00, goal_pose[k]} : '0)
			       + (w_q[0] ? {2'b00, start_pose[k]} : '0);
			if (sum[k] < {2'b00, lim_min[k]}) begin
				clamped[k] = lim_min[k];
			end else if (sum[k] > {2'b00, lim_max[k]}) begin
				clamped[k] = lim_max[k];
			end else begin
				clamped[k] = sum[k][efapi_pkg::ANGLE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// the top bit of e weighs ONE and is added without the shift
	always_ff @(posedge clk) begin
		if (start) begin
			e_q   <= e;
			w_q   <= {1'b1, {FRAC_BITS{1'b0}}} - e;
			acc_q <= '0;
		end else if (run_q) begin
			e_q <= {1'b0, e_q[FRAC_BITS:1]};
			w_q <= {1'b0, w_q[FRAC_BITS:1]};
			for (int k = 0; k < efapi_pkg::JOINTS; k++) begin
				acc_q[k] <= sum[k][SUM_W-1:1];
			end
			if (last) begin
				pose_q <= clamped;
			end
		end
	end

	assign done = done_q;
	assign pose = pose_q;

endmodule

>>> hw/rtl/eased_four_axis_pose_interpolator.sv
`timescale 1ns / 1ps

// Motion profile generator for four servo joints (base, lower, middle, head).
// Input stream: tuser = 0 starts a move (goal pose, duration in ms, easing
// curve from tdata); tuser = 1 is a one-millisecond tick. Every input transfer
// yields exactly one output transfer carrying the commanded pose and the
// in_motion, arrived and near_neutral flags. Joint limits are written through
// the cfg port (index 0..7: base min/max, lower, middle, head); the user must
// write them only while idle, as the block itself does not enforce this.
// One item is handled at a time. An idle tick, an arrival or a zero-length
// move goes from EVAL straight to OUT, skipping the serial units. A blended
// step runs a bit-serial divider, then no multiply for linear, one for
// ease-out and ease-in-out and two for cubic ease-in, then the bit-serial
// blend lanes; each serial unit retires one bit per cycle. Reset puts the
// start, goal and present poses at 90 degrees, limits at 0..180, and the
// block idle. The result sits in an output register; the next input transfer
// is taken while it waits. If the receiver stalls, a finished result holds in
// its staging register until the output register frees, and input waits.
module eased_four_axis_pose_interpolator #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// goal_base[7:0], goal_lower[15:8], goal_middle[23:16], goal_head[31:24],
	// move_time[47:32], curve[49:48], zero pad[55:50]
	input  logic [55:0]                 s_axis_tdata,
	// kind[0]
	input  logic                        s_axis_tuser,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// angle_base[7:0], angle_lower[15:8], angle_middle[23:16], angle_head[31:24],
	// in_motion[32], arrived[33], near_neutral[34], zero pad[39:35]
	output logic [39:0]                 m_axis_tdata,
	input  logic                        cfg_we,
	input  efapi_pkg::reg_idx_t         cfg_index,
	input  efapi_pkg::angle_t           cfg_wdata
);

	localparam int GOAL_LSB  = 0;
	localparam int GOAL_W    = efapi_pkg::JOINTS * efapi_pkg::ANGLE_W;
	localparam int TIME_LSB  = GOAL_LSB + GOAL_W;
	localparam int CURVE_LSB = TIME_LSB + efapi_pkg::TIME_W;

	efapi_pkg::state_t  state_q, state_nx;

	// move state
	efapi_pkg::pose_t   start_q, goal_q, present_q;
	efapi_pkg::ms_t     elapsed_q, total_q;
	efapi_pkg::curve_t  curve_q;
	logic               busy_q;
	logic [FRAC_BITS-1:0] t_q;

	// limits
	efapi_pkg::pose_t   lim_min_q, lim_max_q;

	// staged result and output register
	efapi_pkg::pose_t   res_pose_q;
	logic               res_motion_q;
	logic               res_arrived_q;
	logic               m_valid_q;
	logic [39:0]        m_data_q;

	logic               arrive;
	logic               accept;
	logic               out_load;
	logic               near;

	// serial unit hookup
	logic                 div_start, div_done;
	logic [FRAC_BITS-1:0] div_quo;
	logic                 mul_start, mul_done;
	logic [FRAC_BITS+1:0] mul_a, mul_hi;
	logic [FRAC_BITS-1:0] mul_b;
	logic                 blend_start, blend_done;
	logic [FRAC_BITS:0]   blend_e;
	efapi_pkg::pose_t     blend_pose;

	// curve operands
	logic [FRAC_BITS+1:0] a_out;
	logic [FRAC_BITS+2:0] a_io_hi;
	logic [FRAC_BITS+1:0] e_io_hi;
	logic [FRAC_BITS:0]   mul_e;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign arrive = busy_q && (elapsed_q >= total_q);

	// 2*ONE - t, 4*ONE - 2t, and the ease-in-out upper half minus ONE
	assign a_out   = {2'b10, {FRAC_BITS{1'b0}}} - {2'b00, div_quo};
	assign a_io_hi = {3'b100, {FRAC_BITS{1'b0}}} - {2'b00, div_quo, 1'b0};
	assign e_io_hi = mul_hi - {2'b01, {FRAC_BITS{1'b0}}};
	assign mul_e   = (curve_q == efapi_pkg::CURVE_IN_OUT && t_q[FRAC_BITS-1])
	               ? e_io_hi[FRAC_BITS:0] : mul_hi[FRAC_BITS:0];

	// every joint strictly within the tolerance of neutral
	always_comb begin
		near = 1'b1;
		for (int k = 0; k < efapi_pkg::JOINTS; k++) begin
			if (present_q[k] <= efapi_pkg::NEUTRAL_ANGLE - efapi_pkg::NEUTRAL_TOL ||
			    present_q[k] >= efapi_pkg::NEUTRAL_ANGLE + efapi_pkg::NEUTRAL_TOL) begin
				near = 1'b0;
			end
		end
	end

	efapi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (elapsed_q),
		.den    (total_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	efapi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.hi     (mul_hi)
	);

	efapi_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (blend_start),
		.e          (blend_e),
		.start_pose (start_q),
		.goal_pose  (goal_q),
		.lim_min    (lim_min_q),
		.lim_max    (lim_max_q),
		.done       (blend_done),
		.pose       (blend_pose)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			efapi_pkg::ST_IDLE: begin
				if (s_axis_tvalid) state_nx = efapi_pkg::ST_EVAL;
			end
			efapi_pkg::ST_EVAL: begin
				if (arrive || !busy_q) state_nx = efapi_pkg::ST_OUT;
				else state_nx = efapi_pkg::ST_DIV;
			end
			efapi_pkg::ST_DIV: begin
				if (div_done) begin
					case (curve_q)
						efapi_pkg::CURVE_LINEAR:  state_nx = efapi_pkg::ST_BLEND;
						efapi_pkg::CURVE_EASE_IN: state_nx = efapi_pkg::ST_MUL1;
						default:                  state_nx = efapi_pkg::ST_MUL2;
					endcase
				end
			end
			efapi_pkg::ST_MUL1: begin
				if (mul_done) state_nx = efapi_pkg::ST_MUL2;
			end
			efapi_pkg::ST_MUL2: begin
				if (mul_done) state_nx = efapi_pkg::ST_BLEND;
			end
			efapi_pkg::ST_BLEND: begin
				if (blend_done) state_nx = efapi_pkg::ST_OUT;
			end
			efapi_pkg::ST_OUT: begin
				if (!m_valid_q || m_axis_tready) state_nx = efapi_pkg::ST_IDLE;
			end
			default: state_nx = efapi_pkg::ST_IDLE;
		endcase
	end

	// state outputs: unit kicks and operand selection
	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		mul_start     = 1'b0;
		mul_a         = {2'b00, t_q};
		mul_b         = t_q;
		blend_start   = 1'b0;
		blend_e       = {1'b0, t_q};
		out_load      = 1'b0;
		unique case (state_q)
			efapi_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			efapi_pkg::ST_EVAL: begin
				div_start = busy_q && !arrive;
			end
			efapi_pkg::ST_DIV: begin
				mul_b = div_quo;
				if (div_done) begin
					case (curve_q)
						efapi_pkg::CURVE_LINEAR: begin
							blend_start = 1'b1;
							blend_e     = {1'b0, div_quo};
						end
						efapi_pkg::CURVE_EASE_IN: begin
							mul_start = 1'b1;
							mul_a     = {2'b00, div_quo};
						end
						efapi_pkg::CURVE_EASE_OUT: begin
							mul_start = 1'b1;
							mul_a     = a_out;
						end
						efapi_pkg::CURVE_IN_OUT: begin
							mul_start = 1'b1;
							mul_a     = div_quo[FRAC_BITS-1] ? a_io_hi[FRAC_BITS+1:0]
							                                 : {1'b0, div_quo, 1'b0};
						end
					endcase
				end
			end
			efapi_pkg::ST_MUL1: begin
				// second cubic pass: (t*t >> F) * t
				mul_a     = mul_hi;
				mul_start = mul_done;
			end
			efapi_pkg::ST_MUL2: begin
				blend_e     = mul_e;
				blend_start = mul_done;
			end
			efapi_pkg::ST_BLEND: begin
			end
			efapi_pkg::ST_OUT: begin
				out_load = !m_valid_q || m_axis_tready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efapi_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_min_q <= {efapi_pkg::JOINTS{efapi_pkg::LIMIT_MIN_RESET}};
			lim_max_q <= {efapi_pkg::JOINTS{efapi_pkg::LIMIT_MAX_RESET}};
		end else if (cfg_we) begin
			unique case (cfg_index)
				efapi_pkg::REG_BASE_MIN:   lim_min_q[0] <= cfg_wdata;
				efapi_pkg::REG_BASE_MAX:   lim_max_q[0] <= cfg_wdata;
				efapi_pkg::REG_LOWER_MIN:  lim_min_q[1] <= cfg_wdata;
				efapi_pkg::REG_LOWER_MAX:  lim_max_q[1] <= cfg_wdata;
				efapi_pkg::REG_MIDDLE_MIN: lim_min_q[2] <= cfg_wdata;
				efapi_pkg::REG_MIDDLE_MAX: lim_max_q[2] <= cfg_wdata;
				efapi_pkg::REG_HEAD_MIN:   lim_min_q[3] <= cfg_wdata;
				efapi_pkg::REG_HEAD_MAX:   lim_max_q[3] <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// move state: latch a start, advance on a tick, retire on arrival
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q   <= {efapi_pkg::JOINTS{efapi_pkg::NEUTRAL_ANGLE}};
			goal_q    <= {efapi_pkg::JOINTS{efapi_pkg::NEUTRAL_ANGLE}};
			present_q <= {efapi_pkg::JOINTS{efapi_pkg::NEUTRAL_ANGLE}};
			elapsed_q <= '0;
			total_q   <= '0;
			curve_q   <= efapi_pkg::CURVE_LINEAR;
			busy_q    <= 1'b0;
		end else if (accept) begin
			if (s_axis_tuser == efapi_pkg::KIND_START) begin
				// abandon any move in flight; start from the last completed pose
				start_q   <= present_q;
				goal_q    <= s_axis_tdata[GOAL_LSB +: GOAL_W];
				total_q   <= s_axis_tdata[TIME_LSB +: efapi_pkg::TIME_W];
				curve_q   <= efapi_pkg::curve_t'(s_axis_tdata[CURVE_LSB +: 2]);
				elapsed_q <= '0;
				busy_q    <= 1'b1;
			end else if (busy_q) begin
				elapsed_q <= elapsed_q + {{(efapi_pkg::TIME_W-1){1'b0}}, 1'b1};
			end
		end else if (state_q == efapi_pkg::ST_EVAL && arrive) begin
			present_q <= goal_q;
			busy_q    <= 1'b0;
		end
	end

	// fraction hold and result staging
	always_ff @(posedge clk) begin
		if (state_q == efapi_pkg::ST_DIV && div_done) begin
			t_q <= div_quo;
		end
		if (state_q == efapi_pkg::ST_EVAL) begin
			if (arrive) begin
				// arrival emits the goal unclamped
				res_pose_q    <= goal_q;
				res_motion_q  <= 1'b0;
				res_arrived_q <= 1'b1;
			end else if (!busy_q) begin
				res_pose_q    <= present_q;
				res_motion_q  <= 1'b0;
				res_arrived_q <= 1'b0;
			end
		end else if (state_q == efapi_pkg::ST_BLEND && blend_done) begin
			res_pose_q    <= blend_pose;
			res_motion_q  <= 1'b1;
			res_arrived_q <= 1'b0;
		end
		if (out_load) begin
			m_data_q <= {5'b00000, near, res_arrived_q, res_motion_q, res_pose_q};
		end
	end

	// output register: drop valid once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule
